// ----- hdl/bpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpu_pkg
// shared types and constants of the bitmask pixel unpacker
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int MAX_SIDE   = 16384;
  localparam int CFG_W      = 32;
  localparam int BPP_W      = 3;
  localparam int SIDE_W     = 15;
  localparam int PITCH_W    = 17;
  localparam int ROW_W      = 14;
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int DIV_STEPS  = 8;
  localparam int STEP_W     = 3;

  localparam logic [BPP_W-1:0]   BPP_MIN   = 3'd2;
  localparam logic [BPP_W-1:0]   BPP_MAX   = 3'd4;
  localparam logic [SIDE_W-1:0]  SIDE_MAX  = SIDE_W'(MAX_SIDE);
  localparam logic [CHAN_W-1:0]  FULL_CHAN = 8'd255;

  // reset values of the configuration registers
  localparam logic [BPP_W-1:0]   RST_BPP   = 3'd4;
  localparam logic [SIDE_W-1:0]  RST_W     = 15'd1;
  localparam logic [SIDE_W-1:0]  RST_H     = 15'd1;
  localparam logic [PITCH_W-1:0] RST_PITCH = 17'd4;
  localparam logic [PIX_W-1:0]   RST_RED   = 32'h00FF_0000;
  localparam logic [PIX_W-1:0]   RST_GREEN = 32'h0000_FF00;
  localparam logic [PIX_W-1:0]   RST_BLUE  = 32'h0000_00FF;
  localparam logic [PIX_W-1:0]   RST_ALPHA = 32'h0000_0000;

  // channel order inside the lane array
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef enum logic [2:0] {
    REG_BPP   = 3'd0,
    REG_WIDTH = 3'd1,
    REG_HEIGHT= 3'd2,
    REG_PITCH = 3'd3,
    REG_RED   = 3'd4,
    REG_GREEN = 3'd5,
    REG_BLUE  = 3'd6,
    REG_ALPHA = 3'd7
  } reg_idx_t;

  // commands from the controller
  typedef struct packed {
    logic accept;    // input byte taken this cycle
    logic align;     // lanes shift mask toward bit 0
    logic prep;      // lanes form field*255 + mask/2
    logic div;       // lanes do one restoring divide step
    logic out_load;  // result goes to the output register
  } ctrl_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic pixel_done;  // current byte completes a pixel
    logic aligned;     // all lanes aligned
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

// ----- hdl/bitmask_pixel_unpack.sv -----
// ----------------------------------------------------------------------------
// bitmask_pixel_unpack
// byte-stream unpacker for 16/24/32-bit bit-mask pixels into 8-bit rgba
// ----------------------------------------------------------------------------
// Raw pixel rows come in one byte per request, lowest byte of each pixel first,
// each row padded out to the configured pitch. A byte that does not finish a
// pixel, and every padding byte, is taken without stalling the input. Once the
// byte that finishes a pixel is taken, the input stalls while the four channel
// lanes first slide their masks down to bit 0 (shift by eight while the low
// byte of the mask is empty, otherwise by one; up to ten shifts), then form
// field*255 + mask/2, then run an eight-step restoring divide, and finally
// load the shared output register. That output register lets the next bytes
// flow in while a result still waits on out_stall. Each result carries row
// end, image end and a mask fault flag (empty color mask, noncontiguous mask,
// mask wider than the pixel, or overlapping masks); pixels are still delivered
// when the flag is set. An empty alpha mask reads as 255. Configuration
// registers are plain writes and should only change while the block is idle;
// stream counters are not cleared by a write.
// ----------------------------------------------------------------------------
module bitmask_pixel_unpack
  import bpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  // configuration write port
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,

  // byte request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,

  // pixel result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_row_end,
  output logic             out_image_end,
  output logic             out_mask_fault
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: owns the input stall and steps the lanes
  bpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, row/pixel counters, scaling lanes, output stage
  bpu_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_data_byte   (in_data_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .out_mask_fault (out_mask_fault)
  );

endmodule

// ----- hdl/bpu_scale_lane.sv -----
// ----------------------------------------------------------------------------
// bpu_scale_lane
// one color channel: mask alignment and scaling to 0..255 by restoring divide
// ----------------------------------------------------------------------------
module bpu_scale_lane
  import bpu_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  ctrl_cmd_t         cmd,
  input  logic [PIX_W-1:0]  px,
  input  logic [PIX_W-1:0]  mask,
  output logic [CHAN_W-1:0] value,
  output logic              aligned,
  output logic              contig
);

  localparam int REM_W = PIX_W + CHAN_W;
  localparam int DIV_W = PIX_W + DIV_STEPS - 1;

  logic [PIX_W-1:0]  field_r;
  logic [PIX_W-1:0]  mask_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  div_r;
  logic [CHAN_W-1:0] quo_r;
  logic [REM_W-1:0]  prep_sum;
  logic              fits;
  logic              mask_zero;

  assign mask_zero = (mask_r == '0);
  assign aligned   = mask_zero | mask_r[0];
  assign contig    = ((mask_r + PIX_W'(1)) & mask_r) == '0;

  // field*255 + mask/2, never above 40 bits
  assign prep_sum = {field_r, 8'd0} - {8'd0, field_r} + {9'd0, mask_r[PIX_W-1:1]};
  assign fits     = (rem_r >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (load) begin
      field_r <= px & mask;
      mask_r  <= mask;
    end else if (cmd.align && !aligned) begin
      if (mask_r[7:0] == 8'd0) begin
        field_r <= field_r >> 8;
        mask_r  <= mask_r >> 8;
      end else begin
        field_r <= field_r >> 1;
        mask_r  <= mask_r >> 1;
      end
    end

    if (cmd.prep) begin
      rem_r <= prep_sum;
      div_r <= {mask_r, 7'd0};
    end else if (cmd.div) begin
      if (fits) begin
        rem_r <= rem_r - {1'b0, div_r};
      end
      div_r <= div_r >> 1;
      quo_r <= {quo_r[CHAN_W-2:0], fits};
    end
  end

  assign value = mask_zero ? FULL_CHAN : quo_r;

endmodule

// ----- hdl/bpu_datapath.sv -----
// ----------------------------------------------------------------------------
// bpu_datapath
// configuration, byte counters, pixel gather, scaling lanes and output register
// ----------------------------------------------------------------------------
module bpu_datapath
  import bpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [7:0]        in_data_byte,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_row_end,
  output logic              out_image_end,
  output logic              out_mask_fault
);

  // configuration registers
  logic [BPP_W-1:0]   bpp_r;
  logic [SIDE_W-1:0]  width_r;
  logic [SIDE_W-1:0]  height_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [PIX_W-1:0]   mask_r [NUM_CHAN];

  // stream position
  logic [PIX_W-1:0]   gather_r, gather_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [PITCH_W-1:0] bir_r, bir_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               row_end_r, image_end_r;

  // output register
  logic               out_valid_r;
  logic [CHAN_W-1:0]  chan_out_r [NUM_CHAN];
  logic               row_end_out_r, image_end_out_r, fault_out_r;

  logic [BPP_W-1:0]   bpp_eff;
  logic [SIDE_W-1:0]  w_eff, h_eff;
  logic [PITCH_W-1:0] tight, pitch_eff;
  logic [PITCH_W:0]   pos_inc;
  logic               in_pixel, last_row, pix_last, row_done, row_last;
  logic [PIX_W-1:0]   gather_or;
  logic [CHAN_W-1:0]  lane_val [NUM_CHAN];
  logic [NUM_CHAN-1:0] lane_aligned, lane_contig;
  logic [NUM_CHAN-1:0] lane_ok;
  logic               fault;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (v > SIDE_MAX) begin
      return SIDE_MAX;
    end
    return v;
  endfunction

  function automatic logic too_wide(input logic [PIX_W-1:0] m, input logic [BPP_W-1:0] bpp);
    logic r;
    case (bpp)
      3'd2:    r = |m[31:16];
      3'd3:    r = |m[31:24];
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r            <= RST_BPP;
      width_r          <= RST_W;
      height_r         <= RST_H;
      pitch_r          <= RST_PITCH;
      mask_r[CH_RED]   <= RST_RED;
      mask_r[CH_GREEN] <= RST_GREEN;
      mask_r[CH_BLUE]  <= RST_BLUE;
      mask_r[CH_ALPHA] <= RST_ALPHA;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BPP:    bpp_r            <= cfg_wdata[BPP_W-1:0];
        REG_WIDTH:  width_r          <= cfg_wdata[SIDE_W-1:0];
        REG_HEIGHT: height_r         <= cfg_wdata[SIDE_W-1:0];
        REG_PITCH:  pitch_r          <= cfg_wdata[PITCH_W-1:0];
        REG_RED:    mask_r[CH_RED]   <= cfg_wdata;
        REG_GREEN:  mask_r[CH_GREEN] <= cfg_wdata;
        REG_BLUE:   mask_r[CH_BLUE]  <= cfg_wdata;
        REG_ALPHA:  mask_r[CH_ALPHA] <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (bpp_r < BPP_MIN) begin
      bpp_eff = BPP_MIN;
    end else if (bpp_r > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = bpp_r;
    end
    w_eff = clamp_side(width_r);
    h_eff = clamp_side(height_r);
    case (bpp_eff)
      3'd2:    tight = {1'b0, w_eff, 1'b0};
      3'd3:    tight = {2'b0, w_eff} + {1'b0, w_eff, 1'b0};
      default: tight = {w_eff, 2'b0};
    endcase
    pitch_eff = (pitch_r < tight) ? tight : pitch_r;
  end

  assign pos_inc   = {1'b0, bir_r} + (PITCH_W+1)'(1);
  assign in_pixel  = (bir_r < tight);
  assign last_row  = ({1'b0, row_r} + SIDE_W'(1)) >= h_eff;
  assign pix_last  = ({1'b0, bip_r} + BPP_W'(1)) >= bpp_eff;
  assign row_last  = pos_inc >= {1'b0, tight};
  assign row_done  = pos_inc >= {1'b0, pitch_eff};
  assign gather_or = gather_r | ({24'd0, in_data_byte} << {bip_r, 3'b000});

  // next stream position for an accepted byte
  always_comb begin
    gather_nxt = gather_r;
    bip_nxt    = bip_r;
    bir_nxt    = bir_r;
    row_nxt    = row_r;
    if (in_pixel) begin
      if (pix_last) begin
        gather_nxt = '0;
        bip_nxt    = '0;
      end else begin
        gather_nxt = gather_or;
        bip_nxt    = bip_r + 2'd1;
      end
    end
    if (row_done) begin
      bir_nxt    = '0;
      gather_nxt = '0;
      bip_nxt    = '0;
      row_nxt    = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      bir_nxt = pos_inc[PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      bip_r    <= '0;
      bir_r    <= '0;
      row_r    <= '0;
    end else if (cmd.accept) begin
      gather_r <= gather_nxt;
      bip_r    <= bip_nxt;
      bir_r    <= bir_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.pixel_done) begin
      row_end_r   <= row_last;
      image_end_r <= row_last && last_row;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    bpu_scale_lane u_lane (
      .clk     (clk),
      .load    (cmd.accept && sts.pixel_done),
      .cmd     (cmd),
      .px      (gather_or),
      .mask    (mask_r[c]),
      .value   (lane_val[c]),
      .aligned (lane_aligned[c]),
      .contig  (lane_contig[c])
    );
    assign lane_ok[c] = (mask_r[c] != '0) && !too_wide(mask_r[c], bpp_eff) && lane_contig[c];
  end

  // color masks must be usable; alpha may be empty; no two may share a bit
  assign fault = !lane_ok[CH_RED] || !lane_ok[CH_GREEN] || !lane_ok[CH_BLUE]
              || ((mask_r[CH_ALPHA] != '0) && !lane_ok[CH_ALPHA])
              || |(mask_r[CH_RED] & mask_r[CH_GREEN])
              || |(mask_r[CH_RED] & mask_r[CH_BLUE])
              || |(mask_r[CH_GREEN] & mask_r[CH_BLUE])
              || |(mask_r[CH_ALPHA] & (mask_r[CH_RED] | mask_r[CH_GREEN] | mask_r[CH_BLUE]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        chan_out_r[c] <= lane_val[c];
      end
      row_end_out_r   <= row_end_r;
      image_end_out_r <= image_end_r;
      fault_out_r     <= fault;
    end
  end

  assign sts.pixel_done = in_pixel && pix_last;
  assign sts.aligned    = &lane_aligned;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_red        = chan_out_r[CH_RED];
  assign out_green      = chan_out_r[CH_GREEN];
  assign out_blue       = chan_out_r[CH_BLUE];
  assign out_alpha      = chan_out_r[CH_ALPHA];
  assign out_row_end    = row_end_out_r;
  assign out_image_end  = image_end_out_r;
  assign out_mask_fault = fault_out_r;

endmodule

// ----- hdl/bpu_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpu_ctrl
// sequencer for byte intake, mask alignment, divide steps and result load
// ----------------------------------------------------------------------------
module bpu_ctrl
  import bpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALIGN = 5'b00010,
    S_PREP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.pixel_done) begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        if (sts.aligned) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
